### hdl/assert_macros.svh
// Assertion macros for the checker file of this project.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lbp checker: assertion failed");

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("lbp checker: assertion failed");

`endif

### hdl/lbp_pkg.sv
// Shared types, constants and the pattern function of the 3x3 LBP block.
// Used by every module of the block; depends on nothing.
package lbp_pkg;

  localparam int PIX_BITS      = 8;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int WIDTH_RESET   = 640;
  localparam int HEIGHT_RESET  = 480;
  localparam int FW_BITS       = 11;
  localparam int FH_BITS       = 13;
  localparam int CFG_BITS      = 13;
  localparam int ROW_BITS      = 12;
  localparam int OUTQ_DEPTH    = 8;

  typedef logic [PIX_BITS-1:0] pix_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    op_t  operation;
    pix_t pixel_value;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] lbp_code;
    logic       last_in_run;
    logic       frame_done;
  } out_beat_t;

  // One window column, top row to bottom row.
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } column_t;

  typedef struct packed {
    logic restart;
    logic shift;
    logic dbl;
  } cell_ctrl_t;

  // Pattern of a window given as left, centre and right columns.
  function automatic logic [7:0] lbp_code(column_t l, column_t c, column_t r);
    logic [7:0] v;
    v[7] = (l.top >= c.mid);
    v[6] = (c.top >= c.mid);
    v[5] = (r.top >= c.mid);
    v[4] = (r.mid >= c.mid);
    v[3] = (r.bot >= c.mid);
    v[2] = (c.bot >= c.mid);
    v[1] = (l.bot >= c.mid);
    v[0] = (l.mid >= c.mid);
    return v;
  endfunction

endpackage

### hdl/lbp_line_store.sv
// One line store: a single-port-write, single-port-read pixel memory.
// Read data is registered. Depends on lbp_pkg.
module lbp_line_store #(
  parameter int DEPTH = lbp_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(lbp_pkg::MAX_WIDTH_DEF)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  lbp_pkg::pix_t     wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output lbp_pkg::pix_t     rdata
);

  lbp_pkg::pix_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/lbp_col_cell.sv
// One column cell of the 3x3 window chain.
// Takes its right neighbor's column, or the one two places over. Depends on lbp_pkg.
module lbp_col_cell (
  input  logic                clk,
  input  logic                rst,
  input  lbp_pkg::cell_ctrl_t ctrl,
  input  lbp_pkg::column_t    near,
  input  lbp_pkg::column_t    far,
  output lbp_pkg::column_t    col
);

  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      col <= '0;
    end else if (ctrl.shift) begin
      // A double step happens at the end of a row, where a blank column follows.
      col <= ctrl.dbl ? far : near;
    end
  end

endmodule

### hdl/lbp_out_fifo.sv
// Small result queue that takes up to two beats per cycle and gives one while out_stall is low.
// Depends on lbp_pkg.
module lbp_out_fifo #(
  parameter int DEPTH = lbp_pkg::OUTQ_DEPTH,
  parameter int CW    = $clog2(lbp_pkg::OUTQ_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push0,
  input  lbp_pkg::out_beat_t  data0,
  input  logic                push1,
  input  lbp_pkg::out_beat_t  data1,
  output logic                out_valid,
  input  logic                out_stall,
  output lbp_pkg::out_beat_t  out_data,
  output logic [CW-1:0]       count
);

  localparam int PW = $clog2(DEPTH);

  lbp_pkg::out_beat_t mem [DEPTH];
  logic [PW-1:0]      head;
  logic [PW-1:0]      tail;
  logic               pop;
  logic [CW-1:0]      count_next;

  assign out_valid = (count != '0);
  assign out_data  = mem[head];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    count_next = count + CW'(push0) + CW'(push1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem[tail] <= data0;
    end
    if (push1) begin
      mem[tail + PW'(1)] <= data1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head + PW'(1);
      end
      tail  <= tail + PW'(push0) + PW'(push1);
      count <= count_next;
    end
  end

endmodule

### hdl/lbp_3x3_pixel_stream.sv
// Top level of the 3x3 local binary pattern block over a raster pixel stream.
// Instantiates the line stores, the window cells and the result queue; uses lbp_pkg.
//
// One beat can be taken every clock while in_stall is low. A taken beat and the
// line store reads are registered into the second stage, where the window steps
// and the pattern enters the result queue, and the queue then presents it. The
// pixel that ends a row (from the second row on) gives two results and the first
// pixel of a row gives none, so each such row gives width results and the queue,
// handing out one per clock while out_stall is low, keeps pace. The queue is
// eight deep and the input is held off only when it could overflow, which can
// happen only after the output side has stalled. A frame of W by H pixels is
// followed by W+1 drain beats that flush the last row. There is no clearing pass
// after reset: the line stores' data is only used from rows that have already
// been written in the current frame.
module lbp_3x3_pixel_stream #(
  parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lbp_pkg::in_beat_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lbp_pkg::out_beat_t            out_data,
  input  logic                          cfg_write,
  input  lbp_pkg::reg_index_t           cfg_index,
  input  logic [lbp_pkg::CFG_BITS-1:0]  cfg_data
);

  localparam int AW        = $clog2(MAX_WIDTH);
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int HW        = lbp_pkg::FH_BITS;
  localparam int RW        = lbp_pkg::ROW_BITS;
  localparam int CW        = $clog2(lbp_pkg::OUTQ_DEPTH + 1);
  localparam int WIDTH_RST = (lbp_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                : lbp_pkg::WIDTH_RESET;

  // Frame control.
  logic [WW-1:0] width_eff;
  logic [HW-1:0] height_eff;
  logic [AW-1:0] col_cnt;
  logic [RW-1:0] row_cnt;
  logic [WW-1:0] drain_cnt;
  logic          awaiting;

  logic [WW-1:0] width_cfg;
  logic [HW-1:0] height_cfg;
  logic [lbp_pkg::FW_BITS-1:0] wd;
  logic [HW-1:0] hd;

  logic          accept;
  logic          is_pix;
  logic          pix_go;
  logic          drn_go;
  logic          last_col;
  logic          last_row;
  logic          row_ge1;
  logic          row_ge2;
  logic          drain_in;
  logic [AW-1:0] rd_addr;

  // Second stage: line store data arrives and the window steps.
  logic          s1_valid;
  logic          s1_write;
  logic [AW-1:0] s1_addr;
  lbp_pkg::pix_t s1_bot;
  logic          s1_gate_u;
  logic          s1_gate_m;
  logic          s1_clear;
  logic          s1_dbl;
  logic          s1_res_a;
  logic          s1_res_b;
  logic          s1_done;
  logic          fwd_hit;
  lbp_pkg::pix_t fwd_up;
  lbp_pkg::pix_t fwd_mid;

  lbp_pkg::pix_t up_rd;
  lbp_pkg::pix_t mid_rd;
  lbp_pkg::pix_t up_data;
  lbp_pkg::pix_t mid_data;
  logic          mem_we;

  lbp_pkg::column_t   new_col;
  lbp_pkg::column_t   col0;
  lbp_pkg::column_t   col1;
  lbp_pkg::column_t   col2;
  lbp_pkg::column_t   g1;
  lbp_pkg::column_t   g2;
  lbp_pkg::cell_ctrl_t cell_ctrl;

  lbp_pkg::out_beat_t beat_a;
  lbp_pkg::out_beat_t beat_b;
  logic               push0;
  logic               push1;
  lbp_pkg::out_beat_t data0;
  logic [CW-1:0]      fifo_cnt;
  logic [CW-1:0]      s1_n;

  // Config values are clipped to their range on write; width uses low FW_BITS bits.
  always_comb begin
    wd = cfg_data[lbp_pkg::FW_BITS-1:0];
    hd = cfg_data[HW-1:0];
    if (wd == '0) begin
      width_cfg = WW'(1);
    end else if (32'(wd) > MAX_WIDTH) begin
      width_cfg = WW'(MAX_WIDTH);
    end else begin
      width_cfg = WW'(wd);
    end
    if (hd == '0) begin
      height_cfg = HW'(1);
    end else if (32'(hd) > lbp_pkg::MAX_HEIGHT) begin
      height_cfg = HW'(lbp_pkg::MAX_HEIGHT);
    end else begin
      height_cfg = hd;
    end
  end

  always_comb begin
    accept   = in_valid && !in_stall;
    is_pix   = (in_data.operation == lbp_pkg::OP_PIXEL);
    pix_go   = accept && is_pix && !awaiting;
    drn_go   = accept && !is_pix && awaiting;
    last_col = ((WW'(col_cnt) + WW'(1)) >= width_eff);
    last_row = ((HW'(row_cnt) + HW'(1)) >= height_eff);
    row_ge1  = (row_cnt != '0);
    row_ge2  = (row_cnt >= RW'(2));
    drain_in = (drain_cnt < width_eff);
    rd_addr  = is_pix ? col_cnt : drain_cnt[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= WW'(WIDTH_RST);
      height_eff <= HW'(lbp_pkg::HEIGHT_RESET);
      col_cnt    <= '0;
      row_cnt    <= '0;
      drain_cnt  <= '0;
      awaiting   <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        lbp_pkg::REG_FRAME_WIDTH:  width_eff  <= width_cfg;
        lbp_pkg::REG_FRAME_HEIGHT: height_eff <= height_cfg;
        default: ;
      endcase
      col_cnt   <= '0;
      row_cnt   <= '0;
      drain_cnt <= '0;
      awaiting  <= 1'b0;
    end else if (pix_go) begin
      if (last_col) begin
        col_cnt <= '0;
        if (last_row) begin
          awaiting <= 1'b1;
        end else begin
          row_cnt <= row_cnt + RW'(1);
        end
      end else begin
        col_cnt <= col_cnt + AW'(1);
      end
    end else if (drn_go) begin
      if (drain_in) begin
        drain_cnt <= drain_cnt + WW'(1);
      end else begin
        col_cnt   <= '0;
        row_cnt   <= '0;
        drain_cnt <= '0;
        awaiting  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= pix_go || drn_go;
    end
  end

  always_ff @(posedge clk) begin
    // A write from the second stage to the address read now is not yet in the memory.
    fwd_hit <= s1_valid && s1_write && (s1_addr == rd_addr);
    fwd_up  <= mid_data;
    fwd_mid <= s1_bot;
    s1_addr <= rd_addr;
    if (is_pix) begin
      s1_write  <= 1'b1;
      s1_bot    <= in_data.pixel_value;
      s1_gate_u <= row_ge2;
      s1_gate_m <= row_ge1;
      s1_clear  <= (col_cnt == '0);
      s1_res_a  <= row_ge1 && (col_cnt != '0);
      s1_res_b  <= row_ge1 && last_col;
      s1_dbl    <= row_ge1 && last_col;
      s1_done   <= 1'b0;
    end else begin
      s1_write  <= 1'b0;
      s1_bot    <= '0;
      s1_gate_u <= drain_in && (height_eff >= HW'(2));
      s1_gate_m <= drain_in;
      s1_clear  <= (drain_cnt == '0);
      s1_res_a  <= (drain_cnt != '0);
      s1_res_b  <= 1'b0;
      s1_dbl    <= 1'b0;
      s1_done   <= !drain_in;
    end
  end

  assign mem_we   = s1_valid && s1_write;
  assign up_data  = fwd_hit ? fwd_up : up_rd;
  assign mid_data = fwd_hit ? fwd_mid : mid_rd;

  lbp_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_upper (
    .clk   (clk),
    .we    (mem_we),
    .waddr (s1_addr),
    .wdata (mid_data),
    .re    (pix_go || drn_go),
    .raddr (rd_addr),
    .rdata (up_rd)
  );

  lbp_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_middle (
    .clk   (clk),
    .we    (mem_we),
    .waddr (s1_addr),
    .wdata (s1_bot),
    .re    (pix_go || drn_go),
    .raddr (rd_addr),
    .rdata (mid_rd)
  );

  // Window chain. The first row of the frame uses no line store data.
  always_comb begin
    new_col.top = s1_gate_u ? up_data : '0;
    new_col.mid = s1_gate_m ? mid_data : '0;
    new_col.bot = s1_bot;
    g1 = s1_clear ? '0 : col1;
    g2 = s1_clear ? '0 : col2;
    cell_ctrl.restart = cfg_write;
    cell_ctrl.shift   = s1_valid;
    cell_ctrl.dbl     = s1_dbl;
  end

  lbp_col_cell u_cell0 (
    .clk  (clk),
    .rst  (rst),
    .ctrl (cell_ctrl),
    .near (g1),
    .far  (g2),
    .col  (col0)
  );

  lbp_col_cell u_cell1 (
    .clk  (clk),
    .rst  (rst),
    .ctrl (cell_ctrl),
    .near (g2),
    .far  (new_col),
    .col  (col1)
  );

  lbp_col_cell u_cell2 (
    .clk  (clk),
    .rst  (rst),
    .ctrl (cell_ctrl),
    .near (new_col),
    .far  ('0),
    .col  (col2)
  );

  // Result after one step, then the one after the blank column at the row end.
  always_comb begin
    beat_a.lbp_code    = lbp_pkg::lbp_code(g1, g2, new_col);
    beat_a.last_in_run = !s1_res_b;
    beat_a.frame_done  = s1_done;
    beat_b.lbp_code    = lbp_pkg::lbp_code(g2, new_col, '0);
    beat_b.last_in_run = 1'b1;
    beat_b.frame_done  = 1'b0;
    push0 = s1_valid && (s1_res_a || s1_res_b);
    push1 = s1_valid && s1_res_a && s1_res_b;
    data0 = s1_res_a ? beat_a : beat_b;
    s1_n  = s1_valid ? (CW'(s1_res_a) + CW'(s1_res_b)) : '0;
  end

  // Room is kept for the beat in the second stage and two more.
  assign in_stall = ((fifo_cnt + s1_n) > CW'(lbp_pkg::OUTQ_DEPTH - 2));

  lbp_out_fifo #(
    .DEPTH (lbp_pkg::OUTQ_DEPTH),
    .CW    (CW)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push0     (push0),
    .data0     (data0),
    .push1     (push1),
    .data1     (beat_b),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .count     (fifo_cnt)
  );

endmodule

### hdl/lbp_checker.sv
// Port-level checks of the 3x3 LBP block, attached to the top level by bind.
// Depends on lbp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lbp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input lbp_pkg::out_beat_t out_data
);

  // A waiting result beat keeps its contents.
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_data))

  // The final result of a frame is always marked last in its run.
  `ASSERT_CLK(a_done_last, clk, rst, out_valid && out_data.frame_done |-> out_data.last_in_run)

  // The input is held off only while results are queued.
  `ASSERT_CLK(a_stall_queued, clk, rst, in_stall |-> out_valid)

  // Reset leaves the queue empty and the input open.
  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, rst |=> !out_valid && !in_stall)

endmodule

bind lbp_3x3_pixel_stream lbp_checker u_lbp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
